>>> rtl/core/nns_pkg.sv
// Shared constants and types for the nearest-neighbor image scaler.
`default_nettype none

package nns_pkg;

  localparam int FRAC_BITS  = 10;
  localparam int MAX_SCALE  = 8;
  localparam int COORD_BITS = 16;

  localparam int STEP_W    = 14;
  localparam int PIX_W     = 8;
  localparam int OUT_W     = 19;
  localparam int CFG_IDX_W = 3;
  localparam int OPND_W    = COORD_BITS + 1;
  localparam int PROD_W    = STEP_W + OPND_W;
  localparam int EDGE_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = EDGE_W + 1 + FRAC_BITS;
  localparam int CNT_W     = $clog2(MAX_SCALE + 1);

  localparam logic [STEP_W-1:0] MAX_STEP  = STEP_W'(MAX_SCALE << FRAC_BITS);
  localparam logic [STEP_W-1:0] UNIT_STEP = STEP_W'(1 << FRAC_BITS);

  localparam logic [FRAC_BITS-1:0] HALF_FRAC = FRAC_BITS'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] HALF_UNIT = ACC_W'(1 << (FRAC_BITS - 1));
  // Rounded difference (value plus half) thresholds.
  localparam logic signed [ACC_W-1:0] ROW_ONE   =
    ACC_W'((1 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
  localparam logic signed [ACC_W-1:0] CLAMP_LIM = ACC_W'((MAX_SCALE + 1) << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STEP     = 3'd0,
    CFG_Y_STEP     = 3'd1,
    CFG_SRC_LEFT   = 3'd2,
    CFG_SRC_TOP    = 3'd3,
    CFG_SRC_WIDTH  = 3'd4,
    CFG_SRC_HEIGHT = 3'd5
  } nns_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_T,
    ST_MUL_R,
    ST_MUL_B,
    ST_FIX,
    ST_ROW_ACC,
    ST_ROW_REP,
    ST_PIX_ACC,
    ST_PIX_XD,
    ST_EMIT,
    ST_END
  } nns_state_t;

endpackage

`default_nettype wire

>>> rtl/core/nns_in_if.sv
// Input channel: source pixel words with valid/ready handshake.
`default_nettype none

interface nns_in_if;
  logic                      valid;
  logic                      ready;
  logic [nns_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nns_out_if.sv
// Output channel: scaled pixel write words with valid/ready handshake.
`default_nettype none

interface nns_out_if;
  logic                      valid;
  logic                      ready;
  logic [nns_pkg::OUT_W-1:0] out_col;
  logic [nns_pkg::OUT_W-1:0] out_row;
  logic [nns_pkg::PIX_W-1:0] pixel_out;
  logic                      last;

  modport source (output valid, output out_col, output out_row, output pixel_out,
                  output last, input ready);
  modport sink (input valid, input out_col, input out_row, input pixel_out,
                input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nearest_neighbor_image_scaler.sv
// A new source pixel is taken only in the idle state, once the last one is done. The first
// pixel of a frame has the shared multiplier and adder round the four scaled edges one after
// another; a pixel that starts a row steps the row position and repeat count. A pixel in a
// skipped row ends with no write; else any writes go out, each held while the output stalls.
// Synchronous reset restores the register defaults and restarts the frame; any register
// write restarts the frame as well.
`default_nettype none

module nearest_neighbor_image_scaler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nns_pkg::COORD_BITS-1:0]  cfg_data,
  nns_in_if.sink                               pix_in,
  nns_out_if.source                            pix_out
);

  // Configuration registers.
  logic [nns_pkg::STEP_W-1:0]     x_step;
  logic [nns_pkg::STEP_W-1:0]     y_step;
  logic [nns_pkg::COORD_BITS-1:0] src_left;
  logic [nns_pkg::COORD_BITS-1:0] src_top;
  logic [nns_pkg::COORD_BITS-1:0] src_width;
  logic [nns_pkg::COORD_BITS-1:0] src_height;
  logic                           cfg_hit;

  nns_pkg::nns_state_t state, state_next;

  logic [nns_pkg::COORD_BITS-1:0] col_count;
  logic [nns_pkg::COORD_BITS-1:0] row_count;
  logic signed [nns_pkg::ACC_W-1:0] acc_x;
  logic signed [nns_pkg::ACC_W-1:0] acc_y;
  logic signed [nns_pkg::ACC_W-1:0] base_x;
  logic [nns_pkg::EDGE_W-1:0]     dest_x;
  logic [nns_pkg::EDGE_W-1:0]     dest_y;
  logic [nns_pkg::EDGE_W-1:0]     edge_left;
  logic [nns_pkg::EDGE_W-1:0]     edge_top;
  logic [nns_pkg::EDGE_W-1:0]     edge_right;
  logic [nns_pkg::EDGE_W-1:0]     edge_bottom;
  logic [nns_pkg::EDGE_W-1:0]     col_rel;
  logic [nns_pkg::EDGE_W-1:0]     row_rel;
  logic [nns_pkg::CNT_W-1:0]      row_repeat;
  logic [nns_pkg::CNT_W-1:0]      xd;
  logic [nns_pkg::CNT_W-1:0]      cnt_c;
  logic [nns_pkg::CNT_W-1:0]      cnt_r;
  logic [nns_pkg::PIX_W-1:0]      pix;
  logic [nns_pkg::PROD_W-1:0]     prod;

  logic                           out_valid;
  logic [nns_pkg::OUT_W-1:0]      out_col;
  logic [nns_pkg::OUT_W-1:0]      out_row;
  logic [nns_pkg::PIX_W-1:0]      pixel_out;
  logic                           last;

  // Effective steps and sizes.
  logic [nns_pkg::STEP_W-1:0]     xs;
  logic [nns_pkg::STEP_W-1:0]     ys;
  logic [nns_pkg::COORD_BITS-1:0] w;
  logic [nns_pkg::COORD_BITS-1:0] h;
  logic                           last_col;
  logic                           last_row;
  logic                           frame_start;

  // Shared multiplier and adder.
  logic [nns_pkg::STEP_W-1:0]       mul_a;
  logic [nns_pkg::OPND_W-1:0]       mul_b;
  logic [nns_pkg::PROD_W-1:0]       mul_p;
  logic signed [nns_pkg::ACC_W-1:0] alu_a;
  logic signed [nns_pkg::ACC_W-1:0] alu_b;
  logic signed [nns_pkg::ACC_W-1:0] alu_sum;
  logic [nns_pkg::EDGE_W-1:0]       unscaled;
  logic [nns_pkg::CNT_W-1:0]        clamp_cnt;
  logic [nns_pkg::CNT_W-1:0]        rep_cnt;
  logic [nns_pkg::EDGE_W-1:0]       edge_fix_r;
  logic [nns_pkg::EDGE_W-1:0]       edge_fix_b;

  logic                           in_accept;
  logic                           out_free;
  logic                           emit_last;
  logic                           emit_row_wrap;

  always_comb begin
    xs = (x_step == '0) ? nns_pkg::STEP_W'(1)
       : ((x_step > nns_pkg::MAX_STEP) ? nns_pkg::MAX_STEP : x_step);
    ys = (y_step == '0) ? nns_pkg::STEP_W'(1)
       : ((y_step > nns_pkg::MAX_STEP) ? nns_pkg::MAX_STEP : y_step);
    w  = (src_width == '0) ? nns_pkg::COORD_BITS'(1) : src_width;
    h  = (src_height == '0) ? nns_pkg::COORD_BITS'(1) : src_height;
    last_col = ({1'b0, col_count} + 1'b1) >= {1'b0, w};
    last_row = ({1'b0, row_count} + 1'b1) >= {1'b0, h};
    frame_start = (col_count == '0) && (row_count == '0);
  end

  assign in_accept     = pix_in.valid && pix_in.ready;
  assign out_free      = !out_valid || pix_out.ready;
  assign emit_row_wrap = (nns_pkg::CNT_W'(cnt_r + 1'b1) == row_repeat);
  assign emit_last     = emit_row_wrap && (nns_pkg::CNT_W'(cnt_c + 1'b1) == xd);

  assign mul_p   = nns_pkg::PROD_W'(mul_a) * nns_pkg::PROD_W'(mul_b);
  assign alu_sum = alu_a + alu_b;

  // Rounded results of the adder: the half unit is already folded into its operands.
  always_comb begin
    unscaled = alu_sum[nns_pkg::FRAC_BITS +: nns_pkg::EDGE_W];
    if (alu_sum[nns_pkg::ACC_W-1]) begin
      clamp_cnt = '0;
    end else if (alu_sum >= nns_pkg::CLAMP_LIM) begin
      clamp_cnt = nns_pkg::CNT_W'(nns_pkg::MAX_SCALE);
    end else begin
      clamp_cnt = alu_sum[nns_pkg::FRAC_BITS +: nns_pkg::CNT_W];
    end
    // A row that has not reached the next output row is skipped.
    rep_cnt    = (alu_sum < nns_pkg::ROW_ONE) ? '0 : clamp_cnt;
    edge_fix_r = (unscaled <= edge_left) ? nns_pkg::EDGE_W'(edge_left + 1'b1) : unscaled;
    edge_fix_b = (unscaled <= edge_top) ? nns_pkg::EDGE_W'(edge_top + 1'b1) : unscaled;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      nns_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (frame_start) begin
            state_next = nns_pkg::ST_MUL_L;
          end else if (col_count == '0) begin
            state_next = nns_pkg::ST_ROW_ACC;
          end else if (row_repeat != '0) begin
            state_next = nns_pkg::ST_PIX_ACC;
          end else begin
            state_next = nns_pkg::ST_END;
          end
        end
      end
      nns_pkg::ST_MUL_L:   state_next = nns_pkg::ST_MUL_T;
      nns_pkg::ST_MUL_T:   state_next = nns_pkg::ST_MUL_R;
      nns_pkg::ST_MUL_R:   state_next = nns_pkg::ST_MUL_B;
      nns_pkg::ST_MUL_B:   state_next = nns_pkg::ST_FIX;
      nns_pkg::ST_FIX:     state_next = nns_pkg::ST_ROW_ACC;
      nns_pkg::ST_ROW_ACC: state_next = nns_pkg::ST_ROW_REP;
      nns_pkg::ST_ROW_REP: begin
        state_next = (rep_cnt != '0) ? nns_pkg::ST_PIX_ACC : nns_pkg::ST_END;
      end
      nns_pkg::ST_PIX_ACC: state_next = nns_pkg::ST_PIX_XD;
      nns_pkg::ST_PIX_XD: begin
        state_next = (clamp_cnt != '0) ? nns_pkg::ST_EMIT : nns_pkg::ST_END;
      end
      nns_pkg::ST_EMIT: begin
        if (out_free && emit_last) begin
          state_next = nns_pkg::ST_END;
        end
      end
      nns_pkg::ST_END:     state_next = nns_pkg::ST_IDLE;
      default:             state_next = nns_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared units and the input handshake.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    alu_a = '0;
    alu_b = '0;
    pix_in.ready = 1'b0;
    unique case (state)
      nns_pkg::ST_IDLE: begin
        pix_in.ready = 1'b1;
      end
      nns_pkg::ST_MUL_L: begin
        mul_a = xs;
        mul_b = {1'b0, src_left};
      end
      nns_pkg::ST_MUL_T: begin
        mul_a = ys;
        mul_b = {1'b0, src_top};
        alu_a = nns_pkg::ACC_W'(prod);
        alu_b = nns_pkg::HALF_UNIT;
      end
      nns_pkg::ST_MUL_R: begin
        mul_a = xs;
        mul_b = {1'b0, src_left} + {1'b0, w};
        alu_a = nns_pkg::ACC_W'(prod);
        alu_b = nns_pkg::HALF_UNIT;
      end
      nns_pkg::ST_MUL_B: begin
        mul_a = ys;
        mul_b = {1'b0, src_top} + {1'b0, h};
        alu_a = nns_pkg::ACC_W'(prod);
        alu_b = nns_pkg::HALF_UNIT;
      end
      nns_pkg::ST_FIX: begin
        alu_a = nns_pkg::ACC_W'(prod);
        alu_b = nns_pkg::HALF_UNIT;
      end
      nns_pkg::ST_ROW_ACC: begin
        alu_a = acc_y;
        alu_b = nns_pkg::ACC_W'(ys);
      end
      nns_pkg::ST_ROW_REP: begin
        // acc_y - dest_y * unit + half, with the half sitting in the fraction bits.
        alu_a = acc_y;
        alu_b = {(nns_pkg::EDGE_W + 1)'(0) - {1'b0, dest_y}, nns_pkg::HALF_FRAC};
      end
      nns_pkg::ST_PIX_ACC: begin
        alu_a = acc_x;
        alu_b = nns_pkg::ACC_W'(xs);
      end
      nns_pkg::ST_PIX_XD: begin
        alu_a = acc_x;
        alu_b = {(nns_pkg::EDGE_W + 1)'(0) - {1'b0, dest_x}, nns_pkg::HALF_FRAC};
      end
      nns_pkg::ST_EMIT: begin
      end
      nns_pkg::ST_END: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Register file; every write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_step     <= nns_pkg::UNIT_STEP;
      y_step     <= nns_pkg::UNIT_STEP;
      src_left   <= '0;
      src_top    <= '0;
      src_width  <= nns_pkg::COORD_BITS'(1);
      src_height <= nns_pkg::COORD_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nns_pkg::CFG_X_STEP:     x_step     <= cfg_data[nns_pkg::STEP_W-1:0];
        nns_pkg::CFG_Y_STEP:     y_step     <= cfg_data[nns_pkg::STEP_W-1:0];
        nns_pkg::CFG_SRC_LEFT:   src_left   <= cfg_data;
        nns_pkg::CFG_SRC_TOP:    src_top    <= cfg_data;
        nns_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_data;
        nns_pkg::CFG_SRC_HEIGHT: src_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_hit = cfg_we && (cfg_index <= nns_pkg::CFG_SRC_HEIGHT);

  // Source position.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (state == nns_pkg::ST_END) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : nns_pkg::COORD_BITS'(row_count + 1'b1);
      end else begin
        col_count <= nns_pkg::COORD_BITS'(col_count + 1'b1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      nns_pkg::ST_IDLE: begin
        if (in_accept) begin
          pix <= pix_in.pixel_in;
          xd  <= '0;
        end
      end
      nns_pkg::ST_MUL_L: begin
        prod <= mul_p;
      end
      nns_pkg::ST_MUL_T: begin
        prod      <= mul_p;
        edge_left <= unscaled;
        base_x    <= nns_pkg::ACC_W'(prod);
      end
      nns_pkg::ST_MUL_R: begin
        prod     <= mul_p;
        edge_top <= unscaled;
        acc_y    <= nns_pkg::ACC_W'(prod);
      end
      nns_pkg::ST_MUL_B: begin
        prod       <= mul_p;
        edge_right <= edge_fix_r;
      end
      nns_pkg::ST_FIX: begin
        edge_bottom <= edge_fix_b;
        dest_y      <= edge_top;
      end
      nns_pkg::ST_ROW_ACC: begin
        acc_y  <= last_row ? signed'({1'b0, edge_bottom, {nns_pkg::FRAC_BITS{1'b0}}})
                           : alu_sum;
        dest_x <= edge_left;
        acc_x  <= base_x;
      end
      nns_pkg::ST_ROW_REP: begin
        row_repeat <= rep_cnt;
        row_rel    <= dest_y - edge_top;
      end
      nns_pkg::ST_PIX_ACC: begin
        acc_x <= last_col ? signed'({1'b0, edge_right, {nns_pkg::FRAC_BITS{1'b0}}})
                          : alu_sum;
      end
      nns_pkg::ST_PIX_XD: begin
        xd      <= clamp_cnt;
        col_rel <= dest_x - edge_left;
        cnt_c   <= '0;
        cnt_r   <= '0;
      end
      nns_pkg::ST_EMIT: begin
        if (out_free) begin
          out_col   <= nns_pkg::OUT_W'(col_rel + nns_pkg::EDGE_W'(cnt_c));
          out_row   <= nns_pkg::OUT_W'(row_rel + nns_pkg::EDGE_W'(cnt_r));
          pixel_out <= pix;
          last      <= emit_last;
          // Rows of one column first, then the next column.
          if (emit_row_wrap) begin
            cnt_r <= '0;
            cnt_c <= nns_pkg::CNT_W'(cnt_c + 1'b1);
          end else begin
            cnt_r <= nns_pkg::CNT_W'(cnt_r + 1'b1);
          end
        end
      end
      nns_pkg::ST_END: begin
        dest_x <= dest_x + nns_pkg::EDGE_W'(xd);
        if (last_col) begin
          dest_y <= dest_y + nns_pkg::EDGE_W'(row_repeat);
        end
      end
      default: begin
      end
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == nns_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_col   = out_col;
  assign pix_out.out_row   = out_row;
  assign pix_out.pixel_out = pixel_out;
  assign pix_out.last      = last;

endmodule

`default_nettype wire
